FILE: sv/debounced_press_length_classifier_assert.svh
// Assertion macros used by the classifier engine.
`ifndef DEBOUNCED_PRESS_LENGTH_CLASSIFIER_ASSERT_SVH
`define DEBOUNCED_PRESS_LENGTH_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dplc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dplc: next-cycle check failed");

`endif

FILE: sv/dplc_pkg.sv
package dplc_pkg;

  localparam int unsigned TimeBitsDef  = 32;
  localparam int unsigned SampleBits   = 32;
  localparam int unsigned CfgTimeBits  = 16;
  localparam int unsigned InDataBits   = 40;
  localparam int unsigned OutDataBits  = 8;
  localparam int unsigned ApbAddrBits  = 4;
  localparam int unsigned ApbDataBits  = 32;

  localparam logic [CfgTimeBits-1:0] DebounceReset  = 16'd25;
  localparam logic [CfgTimeBits-1:0] LongPressReset = 16'd600;
  localparam logic [CfgTimeBits-1:0] HoldReset      = 16'd1600;
  localparam logic                   EnableReset    = 1'b1;

  typedef enum logic [1:0] {
    GESTURE_NONE  = 2'd0,
    GESTURE_SHORT = 2'd1,
    GESTURE_LONG  = 2'd2,
    GESTURE_HOLD  = 2'd3
  } gesture_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_HOLD       = 2'd2,
    REG_ENABLE     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CfgTimeBits-1:0] debounce_time;
    logic [CfgTimeBits-1:0] long_press_time;
    logic [CfgTimeBits-1:0] hold_time;
    logic                   enable;
  } dplc_cfg_t;

endpackage

FILE: sv/dplc_engine.sv
module dplc_engine #(
  parameter int unsigned TIME_BITS = dplc_pkg::TimeBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dplc_pkg::dplc_cfg_t                 cfg_i,
  input  logic                                step_i,
  input  logic [dplc_pkg::SampleBits-1:0]     sample_time_i,
  input  logic                                button_down_i,
  output dplc_pkg::gesture_e                  gesture_o
);
  import dplc_pkg::*;

  `include "debounced_press_length_classifier_assert.svh"

  logic                 last_raw_q, last_raw_d;
  logic                 deb_q, deb_d;
  logic [TIME_BITS-1:0] raw_change_q, raw_change_d;
  logic [TIME_BITS-1:0] press_start_q, press_start_d;
  logic                 hold_rep_q, hold_rep_d;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] since_raw;
  logic [TIME_BITS-1:0] since_press_old;
  logic [TIME_BITS-1:0] since_press_new;
  logic                 deb_change;
  logic                 hold_mid;
  gesture_e             ev;
  logic                 release_ev;
  logic [TIME_BITS+2:0] frozen_state;

  always_comb begin
    now          = TIME_BITS'(sample_time_i);
    raw_change_d = (button_down_i != last_raw_q) ? now : raw_change_q;
    last_raw_d   = button_down_i;
    since_raw    = now - raw_change_d;
    deb_change   = (since_raw >= TIME_BITS'(cfg_i.debounce_time)) && (button_down_i != deb_q);
    deb_d        = deb_change ? button_down_i : deb_q;

    // A new press restarts the press timer and re-arms the hold report.
    press_start_d   = (deb_change && button_down_i) ? now : press_start_q;
    hold_mid        = (deb_change && button_down_i) ? 1'b0 : hold_rep_q;
    since_press_old = now - press_start_q;
    since_press_new = now - press_start_d;

    ev = GESTURE_NONE;
    if (deb_change && !button_down_i && !hold_rep_q) begin
      ev = (since_press_old >= TIME_BITS'(cfg_i.long_press_time)) ? GESTURE_LONG
                                                                   : GESTURE_SHORT;
    end

    hold_rep_d = hold_mid;
    if (deb_d && !hold_mid && (since_press_new >= TIME_BITS'(cfg_i.hold_time))) begin
      hold_rep_d = 1'b1;
      ev         = GESTURE_HOLD;
    end

    gesture_o = cfg_i.enable ? ev : GESTURE_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b0;
      deb_q         <= 1'b0;
      raw_change_q  <= '0;
      press_start_q <= '0;
      hold_rep_q    <= 1'b0;
    end else if (step_i && cfg_i.enable) begin
      last_raw_q    <= last_raw_d;
      deb_q         <= deb_d;
      raw_change_q  <= raw_change_d;
      press_start_q <= press_start_d;
      hold_rep_q    <= hold_rep_d;
    end
  end

  assign release_ev   = (gesture_o == GESTURE_SHORT) || (gesture_o == GESTURE_LONG);
  assign frozen_state = {deb_q, last_raw_q, hold_rep_q, raw_change_q};

  `DPLC_ASSERT_NEXT(a_frozen_when_off, step_i && !cfg_i.enable, $stable(frozen_state))
  `DPLC_ASSERT_NEXT(a_hold_marks_state, step_i && (gesture_o == GESTURE_HOLD), hold_rep_q && deb_q)
  `DPLC_ASSERT_NEXT(a_release_events, step_i && release_ev, !deb_q && !hold_rep_q)
  `DPLC_ASSERT_NOW(a_release_needs_level, release_ev, deb_q && !button_down_i)

endmodule

FILE: sv/debounced_press_length_classifier.sv
// Debounced press-length classifier: each input beat is one poll of a push button
// (millisecond timestamp and sampled level) and gives exactly one output beat with
// the gesture: none, short press, long press or hold. One beat is taken every clock
// cycle unless the result stalls; each poll waits in the input register, is
// classified, and its result beat is presented from the result register.
// A stalled result holds the input register, and the input stalls once both are full.
// Timestamps are held TIME_BITS wide and compared modulo 2^TIME_BITS.
// Registers (APB, byte address 4*i): 0 debounce time, 1 long-press time, 2 hold
// time, 3 enable. Write them only while no beat is in flight.
module debounced_press_length_classifier #(
  parameter int unsigned TIME_BITS = dplc_pkg::TimeBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] sample_time, [32] button_down, [39:33] zero
  input  logic [dplc_pkg::InDataBits-1:0]   s_axis_tdata,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] gesture, [7:2] zero
  output logic [dplc_pkg::OutDataBits-1:0]  m_axis_tdata,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dplc_pkg::ApbAddrBits-1:0]  paddr,
  input  logic [dplc_pkg::ApbDataBits-1:0]  pwdata,
  output logic [dplc_pkg::ApbDataBits-1:0]  prdata,
  output logic                              pready
);
  import dplc_pkg::*;

  dplc_cfg_t cfg_q, cfg_d;
  reg_idx_e  reg_idx;
  logic      cfg_wr;

  logic                  in_valid_q, in_valid_d;
  logic [SampleBits-1:0] in_time_q;
  logic                  in_level_q;
  logic                  out_valid_q, out_valid_d;
  gesture_e              out_gesture_q;
  gesture_e              gesture;
  logic                  advance;
  logic                  step;
  logic                  in_accept;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrBits-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    case (reg_idx)
      REG_DEBOUNCE: begin
        prdata = ApbDataBits'(cfg_q.debounce_time);
        if (cfg_wr) cfg_d.debounce_time = pwdata[CfgTimeBits-1:0];
      end
      REG_LONG_PRESS: begin
        prdata = ApbDataBits'(cfg_q.long_press_time);
        if (cfg_wr) cfg_d.long_press_time = pwdata[CfgTimeBits-1:0];
      end
      REG_HOLD: begin
        prdata = ApbDataBits'(cfg_q.hold_time);
        if (cfg_wr) cfg_d.hold_time = pwdata[CfgTimeBits-1:0];
      end
      REG_ENABLE: begin
        prdata = ApbDataBits'(cfg_q.enable);
        if (cfg_wr) cfg_d.enable = pwdata[0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= DebounceReset;
      cfg_q.long_press_time <= LongPressReset;
      cfg_q.hold_time       <= HoldReset;
      cfg_q.enable          <= EnableReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register and result register; the result register frees as soon as
  // its beat is taken, so a new poll can be classified in the same cycle.
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_time_q  <= s_axis_tdata[SampleBits-1:0];
      in_level_q <= s_axis_tdata[SampleBits];
    end
    if (step) begin
      out_gesture_q <= gesture;
    end
  end

  dplc_engine #(
    .TIME_BITS(TIME_BITS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .step_i        (step),
    .sample_time_i (in_time_q),
    .button_down_i (in_level_q),
    .gesture_o     (gesture)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataBits'(out_gesture_q);

endmodule
